// File: rtl/digraph_square_cipher_assert.svh
// Assertion macros for the digraph square cipher block.
// Used by the top level; expects no other headers.
`ifndef DIGRAPH_SQUARE_CIPHER_ASSERT_SVH
`define DIGRAPH_SQUARE_CIPHER_ASSERT_SVH

// generic form with explicit clock and reset
`define DSC_ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// shorthand for modules with ports named clock and reset
`define DSC_ASSERT(label, prop, msg) \
   `DSC_ASSERT_CLK(label, clock, reset, prop, msg)

`endif

// File: rtl/dsc_pkg.sv
// Shared types and constants for the digraph square cipher.
// No dependencies.
`timescale 1ns / 1ps

package dsc_pkg;

   localparam int unsigned ALPHABET = 26;
   localparam int unsigned CELLS    = 25;
   localparam logic [4:0]  LETTER_J = 5'd9;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_KEY    = 2'd1,
      OP_FINISH = 2'd2,
      OP_PAIR   = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      STAT_OK        = 2'd0,
      STAT_NOT_READY = 2'd1,
      STAT_SAME      = 2'd2,
      STAT_BAD       = 2'd3
   } status_type;

   typedef struct packed {
      logic [1:0] opcode;
      logic [4:0] letter_a;
      logic [4:0] letter_b;
   } req_type;

   typedef struct packed {
      logic [4:0] out_first;
      logic [4:0] out_second;
      logic [1:0] status;
   } rsp_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FILL,
      S_LOOKUP,
      S_READ,
      S_DELIVER
   } state_type;

   typedef struct packed {
      logic clear;       // drop key
      logic place;       // try to place a letter
      logic place_walk;  // letter comes from the fill walk, not the request
      logic walk_clear;
      logic walk_inc;
      logic set_ready;
      logic capture;     // latch pair status, start position reads
      logic lookup;      // register square indexes
      logic deliver;     // load output word
   } ctrl_cmd_type;

   typedef struct packed {
      logic walk_done;
      logic out_free;
   } dp_stat_type;

endpackage

// File: rtl/dsc_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module dsc_ram #(
   parameter int unsigned WIDTH = 5,
   parameter int unsigned DEPTH = 25
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem[rd_addr_a];
      rd_b_ff <= mem[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

// File: rtl/dsc_datapath.sv
// Datapath: key square and letter position RAMs, used flags, fill walk,
// pair lookup and output register. Depends on dsc_pkg and dsc_ram.
`timescale 1ns / 1ps

module dsc_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  dsc_pkg::req_type      req_data,
   input  logic                  csr_wr_en,
   input  logic                  csr_wr_data,
   input  dsc_pkg::ctrl_cmd_type cmd,
   output dsc_pkg::dp_stat_type  stat,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output dsc_pkg::rsp_type      rsp_data
);

   import dsc_pkg::*;

   typedef struct packed {
      logic [2:0] row;
      logic [2:0] col;
   } cell_type;

   function automatic cell_type split_cell(input logic [4:0] idx);
      cell_type   c;
      logic [4:0] base;
      if (idx >= 5'd20) begin
         c.row = 3'd4;
      end else if (idx >= 5'd15) begin
         c.row = 3'd3;
      end else if (idx >= 5'd10) begin
         c.row = 3'd2;
      end else if (idx >= 5'd5) begin
         c.row = 3'd1;
      end else begin
         c.row = 3'd0;
      end
      base  = {c.row, 2'b00} + {2'b00, c.row};
      c.col = 3'(idx - base);
      return c;
   endfunction

   function automatic logic [4:0] join_cell(input logic [2:0] row, input logic [2:0] col);
      return {row, 2'b00} + {2'b00, row} + {2'b00, col};
   endfunction

   // one step around a row or column of five, direction selects +1 or -1
   function automatic logic [2:0] wrap_step(input logic [2:0] v, input logic dec);
      logic [2:0] r;
      if (dec) begin
         r = (v == 3'd0) ? 3'd4 : v - 3'd1;
      end else begin
         r = (v == 3'd4) ? 3'd0 : v + 3'd1;
      end
      return r;
   endfunction

   logic                direction_ff;
   logic [ALPHABET-1:0] used_ff, used_in;
   logic [4:0]          fill_ff, fill_in;
   logic                key_ready_ff, key_ready_in;
   logic [4:0]          walk_ff, walk_in;
   status_type          err_ff, err_in;
   logic [4:0]          idx_a_ff, idx_b_ff;
   logic                rsp_valid_ff, rsp_valid_in;
   rsp_type             rsp_data_ff;

   logic [4:0] pl_letter;
   logic       pl_in_range;
   logic       pl_used;
   logic       place_ok;
   logic [4:0] pos_rd_a, pos_rd_b;
   logic [4:0] pos_addr_a, pos_addr_b;
   logic [4:0] sq_rd_a, sq_rd_b;
   cell_type   cell_a, cell_b;
   cell_type   new_a, new_b;
   logic       a_bad, b_bad;

   // ---- letter placement ----
   assign pl_letter   = cmd.place_walk ? walk_ff : req_data.letter_a;
   assign pl_in_range = (pl_letter < 5'(ALPHABET));
   assign pl_used     = pl_in_range ? used_ff[pl_letter] : 1'b1;
   assign place_ok    = cmd.place && pl_in_range && (pl_letter != LETTER_J) && !pl_used
                        && (fill_ff < 5'(CELLS));

   always_comb begin
      used_in      = used_ff;
      fill_in      = fill_ff;
      key_ready_in = key_ready_ff;
      if (cmd.clear) begin
         used_in      = '0;
         fill_in      = '0;
         key_ready_in = 1'b0;
      end else begin
         if (place_ok) begin
            used_in[pl_letter] = 1'b1;
            fill_in            = fill_ff + 5'd1;
         end
         if (cmd.set_ready) begin
            key_ready_in = 1'b1;
         end
      end
   end

   always_comb begin
      walk_in = walk_ff;
      if (cmd.walk_clear) begin
         walk_in = '0;
      end else if (cmd.walk_inc) begin
         walk_in = walk_ff + 5'd1;
      end
   end

   // ---- pair status ----
   assign a_bad = (req_data.letter_a >= 5'(ALPHABET)) || (req_data.letter_a == LETTER_J);
   assign b_bad = (req_data.letter_b >= 5'(ALPHABET)) || (req_data.letter_b == LETTER_J);

   always_comb begin
      if (!key_ready_ff) begin
         err_in = STAT_NOT_READY;
      end else if (a_bad || b_bad) begin
         err_in = STAT_BAD;
      end else if (req_data.letter_a == req_data.letter_b) begin
         err_in = STAT_SAME;
      end else begin
         err_in = STAT_OK;
      end
   end

   // keep position reads in range for bad letters; result is then unused
   assign pos_addr_a = a_bad ? 5'd0 : req_data.letter_a;
   assign pos_addr_b = b_bad ? 5'd0 : req_data.letter_b;

   // ---- digraph rules ----
   assign cell_a = split_cell(pos_rd_a);
   assign cell_b = split_cell(pos_rd_b);

   always_comb begin
      new_a = cell_a;
      new_b = cell_b;
      if (cell_a.row == cell_b.row) begin
         new_a.col = wrap_step(cell_a.col, direction_ff);
         new_b.col = wrap_step(cell_b.col, direction_ff);
      end else if (cell_a.col == cell_b.col) begin
         new_a.row = wrap_step(cell_a.row, direction_ff);
         new_b.row = wrap_step(cell_b.row, direction_ff);
      end else begin
         new_a.col = cell_b.col;
         new_b.col = cell_a.col;
      end
   end

   // ---- output word ----
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.deliver) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         direction_ff <= 1'b0;
         used_ff      <= '0;
         fill_ff      <= '0;
         key_ready_ff <= 1'b0;
         walk_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            direction_ff <= csr_wr_data;
         end
         used_ff      <= used_in;
         fill_ff      <= fill_in;
         key_ready_ff <= key_ready_in;
         walk_ff      <= walk_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         err_ff <= err_in;
      end
      if (cmd.lookup) begin
         idx_a_ff <= join_cell(new_a.row, new_a.col);
         idx_b_ff <= join_cell(new_b.row, new_b.col);
      end
      if (cmd.deliver) begin
         if (err_ff == STAT_OK) begin
            rsp_data_ff <= '{out_first: sq_rd_a, out_second: sq_rd_b, status: STAT_OK};
         end else begin
            rsp_data_ff <= '{out_first: 5'd0, out_second: 5'd0, status: err_ff};
         end
      end
   end

   dsc_ram #(.WIDTH(5), .DEPTH(CELLS)) u_square (
      .clock     (clock),
      .wr_en     (place_ok),
      .wr_addr   (fill_ff),
      .wr_data   (pl_letter),
      .rd_addr_a (idx_a_ff),
      .rd_addr_b (idx_b_ff),
      .rd_data_a (sq_rd_a),
      .rd_data_b (sq_rd_b)
   );

   // letter -> cell index, written alongside the square
   dsc_ram #(.WIDTH(5), .DEPTH(ALPHABET)) u_position (
      .clock     (clock),
      .wr_en     (place_ok),
      .wr_addr   (pl_letter),
      .wr_data   (fill_ff),
      .rd_addr_a (pos_addr_a),
      .rd_addr_b (pos_addr_b),
      .rd_data_a (pos_rd_a),
      .rd_data_b (pos_rd_b)
   );

   assign stat.walk_done = (walk_ff == 5'(ALPHABET - 1));
   assign stat.out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_data_ff;

endmodule

// File: rtl/dsc_controller.sv
// Controller state machine: decodes request opcodes and sequences the
// key fill walk and pair lookup. Depends on dsc_pkg.
`timescale 1ns / 1ps

module dsc_controller (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            opcode,
   input  dsc_pkg::dp_stat_type  stat,
   output dsc_pkg::ctrl_cmd_type cmd
);

   import dsc_pkg::*;

   state_type state_ff, state_in;
   op_type    op;

   assign op = op_type'(opcode);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (op == OP_FINISH) begin
                  state_in = S_FILL;
               end else if (op == OP_PAIR) begin
                  state_in = S_LOOKUP;
               end
            end
         end
         S_FILL: begin
            if (stat.walk_done) begin
               state_in = S_IDLE;
            end
         end
         S_LOOKUP:  state_in = S_READ;
         S_READ:    state_in = S_DELIVER;
         S_DELIVER: begin
            if (stat.out_free) begin
               state_in = S_IDLE;
            end
         end
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (op)
                  OP_CLEAR:  cmd.clear      = 1'b1;
                  OP_KEY:    cmd.place      = 1'b1;
                  OP_FINISH: cmd.walk_clear = 1'b1;
                  OP_PAIR:   cmd.capture    = 1'b1;
                  default:   cmd            = '0;
               endcase
            end
         end
         S_FILL: begin
            cmd.place      = 1'b1;
            cmd.place_walk = 1'b1;
            cmd.walk_inc   = 1'b1;
            cmd.set_ready  = stat.walk_done;
         end
         S_LOOKUP:  cmd.lookup  = 1'b1;
         S_READ:    cmd         = '0;
         S_DELIVER: cmd.deliver = stat.out_free;
         default:   cmd         = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: rtl/digraph_square_cipher.sv
// Digraph square (5x5 Playfair) cipher engine, top level.
// Pair word: accepted in idle, then lookup, read and deliver states; deliver waits while rsp stalls.
// Clear and key letter words are taken in idle. Finish word runs the 26-letter fill walk in the fill state.
// Synchronous active-high reset clears key state, direction and output valid; no clearing pass.
// Depends on dsc_pkg, dsc_controller, dsc_datapath, dsc_ram and the assertion header.
`timescale 1ns / 1ps

module digraph_square_cipher (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  dsc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output dsc_pkg::rsp_type rsp_data,
   input  logic             csr_wr_en,
   input  logic             csr_wr_data
);

   import dsc_pkg::*;

   `include "digraph_square_cipher_assert.svh"

   ctrl_cmd_type cmd;
   dp_stat_type  stat;

   dsc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .opcode    (req_data.opcode),
      .stat      (stat),
      .cmd       (cmd)
   );

   dsc_datapath u_dp (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // a pending result is never overwritten
   `DSC_ASSERT(a_no_overwrite, cmd.deliver |-> (!rsp_valid || rsp_ready), "result overwritten")
   // results only come from a delivery
   `DSC_ASSERT(a_rsp_source, $rose(rsp_valid) |-> $past(cmd.deliver), "spurious result")
   // a pair word blocks the input for its lookup
   `DSC_ASSERT(a_pair_busy, (req_valid && req_ready && req_data.opcode == OP_PAIR) |=> !req_ready,
               "input open during lookup")
   // clear and placement never coincide
   `DSC_ASSERT(a_clear_place, !(cmd.clear && cmd.place), "clear and place together")

endmodule
